### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and codes shared by the bitmap slot allocator modules.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned SizeW = 13;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusNoPages = 2'd1,
    StatusNotFound = 2'd2
  } status_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StDivLimit,
    StAllocScan,
    StAllocMul,
    StAllocNew,
    StFreeScan,
    StFreeDiv,
    StFreeClear,
    StDone
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input item, start
    logic div_limit;  // run one division step of PAGE_BYTES / size
    logic div_offs;   // run one division step of offset / size
    logic div_start;  // initialize the divider
    logic scan_step;  // examine one page entry
    logic mul_step;   // one shift-add step of slot * size
    logic mul_start;
    logic open_page;  // write the new page entry
    logic clear_slot; // clear the found slot bit
    logic set_result; // latch result
    logic [1:0] res_status;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_e  op;
    logic div_done;
    logic mul_done;
    logic scan_end;   // scan walked past the last open page
    logic scan_hit;   // current entry hits
    logic zero_slots;
    logic pages_full;
  } sts_t;

endpackage

### hw/rtl/bsa_if.sv
// ----------------------------------------------------------------------------
// bsa_in_if / bsa_out_if
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface bsa_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [47:0] fresh_page;
  logic [47:0] free_addr;
  modport source (output valid, op, fresh_page, free_addr, input ready);
  modport sink   (input valid, op, fresh_page, free_addr, output ready);
endinterface

interface bsa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] obj_addr;
  logic        opened_page;
  modport source (output valid, status, obj_addr, opened_page, input ready);
  modport sink   (input valid, status, obj_addr, opened_page, output ready);
endinterface

### hw/rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer for one allocate or free request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bsa_ctrl import bsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic res_free_i,   // result register empty or draining
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d = StDivLimit;
        end
      end
      StDivLimit: begin
        cmd_o.div_limit = 1'b1;
        if (sts_i.div_done) begin
          if (sts_i.op == OpFree) begin
            cmd_o.div_start = 1'b1;
            state_d = StFreeDiv;
          end else begin
            state_d = StAllocScan;
          end
        end
      end
      StAllocScan: begin
        if (sts_i.zero_slots) begin
          state_d = StDone;
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = StatusNoPages;
        end else if (sts_i.scan_end) begin
          state_d = StAllocNew;
        end else if (sts_i.scan_hit) begin
          cmd_o.mul_start = 1'b1;
          state_d = StAllocMul;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StAllocMul: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = StatusOk;
          state_d = StDone;
        end
      end
      StAllocNew: begin
        cmd_o.set_result = 1'b1;
        if (sts_i.pages_full) begin
          cmd_o.res_status = StatusNoPages;
        end else begin
          cmd_o.open_page = 1'b1;
          cmd_o.res_status = StatusOk;
        end
        state_d = StDone;
      end
      StFreeDiv: begin
        cmd_o.div_offs = 1'b1;
        if (sts_i.div_done) state_d = StFreeScan;
      end
      StFreeScan: begin
        if (sts_i.scan_end) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = StatusNotFound;
          state_d = StDone;
        end else if (sts_i.scan_hit) begin
          state_d = StFreeClear;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StFreeClear: begin
        cmd_o.clear_slot = 1'b1;
        cmd_o.set_result = 1'b1;
        cmd_o.res_status = StatusOk;
        state_d = StDone;
      end
      StDone: begin
        if (res_free_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  `ASSERT_IMPLIES(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == StIdle)
  `ASSERT_NEXT(a_load_leaves, clk_i, rst_ni, cmd_o.load, state_q == StDivLimit)
  `ASSERT_IMPLIES(a_one_write, clk_i, rst_ni, cmd_o.open_page, !cmd_o.clear_slot)
  `ASSERT_NEXT(a_res_done, clk_i, rst_ni, cmd_o.set_result, state_q == StDone)

endmodule

### hw/rtl/bsa_datapath.sv
// ----------------------------------------------------------------------------
// bsa_datapath
// Page table, occupancy maps, restoring divider and shift-add multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bsa_datapath import bsa_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAP_BITS   = 64,
  parameter int unsigned MAX_PAGES  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             op_i,
  input  logic [AddrW-1:0] fresh_page_i,
  input  logic [AddrW-1:0] free_addr_i,
  input  logic [SizeW-1:0] obj_size_i,
  output logic [1:0]       status_o,
  output logic [AddrW-1:0] obj_addr_o,
  output logic             opened_page_o
);

  localparam int unsigned OffW   = $clog2(PAGE_BYTES);
  localparam int unsigned BaseW  = AddrW - OffW;
  localparam int unsigned SlotsMax = 2 * MAP_BITS;
  localparam int unsigned SlotW  = $clog2(SlotsMax);
  localparam int unsigned PgW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CntW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned DivW   = OffW + 1;   // dividend holds PAGE_BYTES
  localparam int unsigned DcW    = $clog2(DivW + 1);
  localparam int unsigned McW    = $clog2(SlotW + 1);

  logic [BaseW-1:0]    base_mem [MAX_PAGES];
  logic [MAP_BITS-1:0] low_q  [MAX_PAGES];
  logic [MAP_BITS-1:0] high_q [MAX_PAGES];
  logic [CntW-1:0]     count_q;

  logic             op_q;
  logic [BaseW-1:0] fresh_q, fbase_q;
  logic [SizeW-1:0] size_q;
  logic [OffW-1:0]  free_addr_q_off;
  logic [OffW-1:0]  foff_q;

  // Restoring divider, one quotient bit per cycle.
  logic [DivW-1:0]  dvd_q, quo_q;
  logic [SizeW:0]   rem_q;
  logic [DcW-1:0]   dcnt_q;
  logic [SizeW:0]   rem_sh;
  logic             rem_ge;
  logic [SlotW:0]   slots_q;   // capped slot count
  logic [DivW-1:0]  slot_q;    // free slot index

  logic [CntW-1:0]  scan_q;
  logic [PgW-1:0]   pidx;
  logic [2*MAP_BITS-1:0] used_vec;
  logic             any_free;
  logic [SlotW-1:0] first_free;

  logic [AddrW-1:0] acc_q, mcand_q;
  logic [SlotW-1:0] mplier_q;
  logic [McW-1:0]   mcnt_q;

  assign pidx = scan_q[PgW-1:0];
  assign rem_sh = {rem_q[SizeW-1:0], dvd_q[DivW-1]};
  assign rem_ge = rem_sh >= {1'b0, size_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      fresh_q <= fresh_page_i[AddrW-1:OffW];
      fbase_q <= free_addr_i[AddrW-1:OffW];
      size_q  <= (obj_size_i == '0) ? SizeW'(1) : obj_size_i;
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= '0;
      if (cmd_i.load) dvd_q <= DivW'(PAGE_BYTES);
      else dvd_q <= {1'b0, free_addr_q_off};
    end else if (cmd_i.div_limit || cmd_i.div_offs) begin
      rem_q  <= rem_ge ? rem_sh - {1'b0, size_q} : rem_sh;
      quo_q  <= {quo_q[DivW-2:0], rem_ge};
      dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      dcnt_q <= dcnt_q + DcW'(1);
    end
    if (sts_o.div_done && cmd_i.div_limit) begin
      slots_q <= ({quo_q[DivW-2:0], rem_ge} > DivW'(SlotsMax)) ?
                 (SlotW+1)'(SlotsMax) : (SlotW+1)'({quo_q[DivW-2:0], rem_ge});
    end
    if (sts_o.div_done && cmd_i.div_offs) slot_q <= {quo_q[DivW-2:0], rem_ge};
    if (cmd_i.mul_start) begin
      acc_q    <= {base_mem[pidx], {OffW{1'b0}}};
      mcand_q  <= AddrW'(size_q);
      mplier_q <= first_free;
      mcnt_q   <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[AddrW-2:0], 1'b0};
      mplier_q <= mplier_q >> 1;
      mcnt_q   <= mcnt_q + McW'(1);
    end
    if (cmd_i.open_page) base_mem[count_q[PgW-1:0]] <= fresh_q;
    if (cmd_i.set_result) begin
      status_o      <= cmd_i.res_status;
      opened_page_o <= cmd_i.open_page;
      if (cmd_i.open_page) obj_addr_o <= {fresh_q, {OffW{1'b0}}};
      else if (cmd_i.mul_step) obj_addr_o <= mplier_q[0] ? acc_q + mcand_q : acc_q;
      else obj_addr_o <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) foff_q <= free_addr_i[OffW-1:0];
  end
  assign free_addr_q_off = foff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      for (int p = 0; p < MAX_PAGES; p++) begin
        low_q[p]  <= '0;
        high_q[p] <= '0;
      end
    end else begin
      if (cmd_i.load) scan_q <= '0;
      else if (cmd_i.scan_step) scan_q <= scan_q + CntW'(1);
      if (cmd_i.mul_start) begin
        if (first_free < SlotW'(MAP_BITS))
          low_q[pidx][first_free[$clog2(MAP_BITS)-1:0]] <= 1'b1;
        else
          high_q[pidx][first_free[$clog2(MAP_BITS)-1:0]] <= 1'b1;
      end
      if (cmd_i.open_page) begin
        low_q[count_q[PgW-1:0]]  <= MAP_BITS'(1);
        high_q[count_q[PgW-1:0]] <= '0;
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.clear_slot && (slot_q < DivW'(slots_q))) begin
        if (slot_q < DivW'(MAP_BITS))
          low_q[pidx][slot_q[$clog2(MAP_BITS)-1:0]] <= 1'b0;
        else
          high_q[pidx][slot_q[$clog2(MAP_BITS)-1:0]] <= 1'b0;
      end
    end
  end

  // Slots at or past the count read as used; priority search for the lowest free.
  always_comb begin
    used_vec = {high_q[pidx], low_q[pidx]};
    any_free = 1'b0;
    first_free = '0;
    for (int i = SlotsMax - 1; i >= 0; i--) begin
      if (!used_vec[i] && (i < int'(slots_q))) begin
        any_free = 1'b1;
        first_free = SlotW'(i);
      end
    end
  end

  assign sts_o.op         = op_e'(op_q);
  assign sts_o.div_done   = (dcnt_q == DcW'(DivW - 1));
  assign sts_o.mul_done   = (mcnt_q == McW'(SlotW - 1));
  assign sts_o.scan_end   = (scan_q >= count_q);
  assign sts_o.scan_hit   = (op_q == OpFree) ? (base_mem[pidx] == fbase_q) : any_free;
  assign sts_o.zero_slots = (slots_q == '0);
  assign sts_o.pages_full = (count_q >= CntW'(MAX_PAGES));

  `ASSERT_IMPLIES(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CntW'(MAX_PAGES))
  `ASSERT_IMPLIES(a_open_room, clk_i, rst_ni, cmd_i.open_page, !sts_o.pages_full)
  `ASSERT_NEXT(a_open_grows, clk_i, rst_ni, cmd_i.open_page, count_q == $past(count_q) + CntW'(1))

endmodule

### hw/rtl/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Fixed-size object allocator over bitmap-tracked pages.
// ----------------------------------------------------------------------------
// channel   dir  beat fields
// in_ch     in   op, fresh_page, free_addr
// out_ch    out  status, obj_addr, opened_page
// apb       in   obj_size at address 0
//
// One item at a time: a division of PAGE_BYTES / size (one bit per cycle),
// plus for a free a second division of the offset by size; then a scan of
// the open pages, and for an allocation on an existing page 7 multiply steps.
// Reset is asynchronous and clears maps and the page count. A stalled result
// holds the block in its final state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAP_BITS   = 64,
  parameter int unsigned MAX_PAGES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsa_in_if.sink      in_ch,
  bsa_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t cmd;
  sts_t sts;
  logic [SizeW-1:0] size_q;
  logic             ovalid_q;
  logic             in_ready;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {19'd0, size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(64);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      size_q <= pwdata[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.set_result) ovalid_q <= 1'b1;
    else if (out_ch.ready) ovalid_q <= 1'b0;
  end

  assign out_ch.valid = ovalid_q;
  assign in_ch.ready  = in_ready;

  bsa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .res_free_i (!ovalid_q || out_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsa_datapath #(
    .PAGE_BYTES (PAGE_BYTES), .MAP_BITS (MAP_BITS), .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (in_ch.op),
    .fresh_page_i  (in_ch.fresh_page),
    .free_addr_i   (in_ch.free_addr),
    .obj_size_i    (size_q),
    .status_o      (out_ch.status),
    .obj_addr_o    (out_ch.obj_addr),
    .opened_page_o (out_ch.opened_page)
  );

  `ASSERT_NEXT(a_res_valid, clk_i, rst_ni, cmd.set_result, out_ch.valid)
  `ASSERT_IMPLIES(a_no_overrun, clk_i, rst_ni, cmd.set_result, !ovalid_q)
  `ASSERT_IMPLIES(a_busy_out, clk_i, rst_ni, ovalid_q, !in_ready)

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_slot_allocator. Requests are driven on the
// input channel with random gaps, and results are taken with random stalls.
// A scoreboard tracks the page table and occupancy maps, predicts every
// result and compares it field by field. The object size is changed over
// APB between phases, between the extremes and several values in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb import bsa_pkg::*; ();

  localparam int unsigned PageBytes = 4096;
  localparam int unsigned MapBits   = 64;
  localparam int unsigned MaxPages  = 16;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 60;
  localparam logic [1:0] RegObjSize = 2'd0;

  typedef struct {
    status_e     status;
    logic [47:0] obj_addr;
    logic        opened_page;
  } alloc_result_t;

  // Page table and occupancy maps mirrored from the outside.
  class alloc_scoreboard;
    logic [47:0]   page_base[MaxPages];
    int unsigned   page_count;
    logic [63:0]   low_map[MaxPages];
    logic [63:0]   high_map[MaxPages];
    logic [12:0]   obj_size;
    alloc_result_t pending_q[$];
    logic [47:0]   live_q[$];
    int unsigned   mismatches;
    int unsigned   requests;
    int unsigned   results;
    int unsigned   opened;
    int unsigned   no_pages;
    int unsigned   not_found;

    function new();
      page_count = 0;
      obj_size = 13'd64;
      mismatches = 0;
      requests = 0;
      results = 0;
      opened = 0;
      no_pages = 0;
      not_found = 0;
      foreach (low_map[p]) begin
        low_map[p] = '0;
        high_map[p] = '0;
        page_base[p] = '0;
      end
    endfunction

    function int unsigned unit_bytes();
      return (obj_size == 0) ? 1 : obj_size;
    endfunction

    function int unsigned slots_per_page();
      int unsigned s;
      s = PageBytes / unit_bytes();
      return (s > 2 * MapBits) ? 2 * MapBits : s;
    endfunction

    function bit slot_taken(int unsigned p, int unsigned i);
      return (i < MapBits) ? low_map[p][i] : high_map[p][i - MapBits];
    endfunction

    function void slot_mark(int unsigned p, int unsigned i, bit v);
      if (i < MapBits) begin
        low_map[p][i] = v;
      end else begin
        high_map[p][i - MapBits] = v;
      end
    endfunction

    function void note_request(op_e op, logic [47:0] fresh, logic [47:0] addr);
      alloc_result_t r;
      int unsigned   nslots;
      logic [47:0]   base;
      int unsigned   slot;
      bit            done;
      nslots = slots_per_page();
      r.status = StatusOk;
      r.obj_addr = '0;
      r.opened_page = 1'b0;
      done = 0;
      requests++;
      if (op == OpAlloc) begin
        if (nslots == 0) begin
          r.status = StatusNoPages;
          done = 1;
        end
        for (int unsigned p = 0; p < page_count && !done; p++) begin
          for (int unsigned i = 0; i < nslots && !done; i++) begin
            if (!slot_taken(p, i)) begin
              slot_mark(p, i, 1);
              r.obj_addr = page_base[p] + 48'(i * unit_bytes());
              done = 1;
            end
          end
        end
        if (!done && page_count >= MaxPages) begin
          r.status = StatusNoPages;
          done = 1;
        end
        if (!done) begin
          page_base[page_count] = fresh & ~48'(PageBytes - 1);
          low_map[page_count] = '0;
          high_map[page_count] = '0;
          slot_mark(page_count, 0, 1);
          r.obj_addr = page_base[page_count];
          r.opened_page = 1'b1;
          page_count++;
        end
        if (r.status == StatusOk) begin
          live_q.push_back(r.obj_addr);
        end
      end else begin
        base = addr & ~48'(PageBytes - 1);
        slot = addr[11:0] / unit_bytes();
        r.status = StatusNotFound;
        for (int unsigned p = 0; p < page_count && !done; p++) begin
          if (page_base[p] == base) begin
            if (slot < nslots) begin
              slot_mark(p, slot, 0);
            end
            r.status = StatusOk;
            done = 1;
          end
        end
        foreach (live_q[k]) begin
          if (live_q[k] == addr) begin
            live_q.delete(k);
            break;
          end
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [47:0] obj_addr, logic opened_page);
      alloc_result_t e;
      results++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result beat status=%0d addr=%h opened=%0b",
                   status, obj_addr, opened_page);
        end
        return;
      end
      e = pending_q.pop_front();
      if (e.opened_page) opened++;
      if (e.status == StatusNoPages) no_pages++;
      if (e.status == StatusNotFound) not_found++;
      if (status !== e.status || obj_addr !== e.obj_addr || opened_page !== e.opened_page) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d expected status=%0d addr=%h opened=%0b", results,
                   e.status, e.obj_addr, e.opened_page);
          $display("       got      status=%0d addr=%h opened=%0b", status, obj_addr,
                   opened_page);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bsa_in_if  in_if ();
  bsa_out_if out_if ();

  bitmap_slot_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  alloc_scoreboard sb = new();
  bit quiet;
  bit hold_request;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                 sb.pending_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_obj_size(logic [12:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegObjSize;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.obj_size = value;
  endtask

  // Valid stays high across back-to-back beats; it is only lowered for a gap.
  task automatic send_request(op_e op, logic [47:0] fresh, logic [47:0] addr);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.fresh_page <= fresh;
    in_if.free_addr <= addr;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(op, fresh, addr);
  endtask

  function automatic logic [47:0] random_addr();
    return {16'($urandom), $urandom};
  endfunction

  task automatic send_random();
    logic [47:0] addr;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55 || sb.page_count == 0) begin
      send_request(OpAlloc, random_addr(), random_addr());
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && sb.live_q.size() > 0) begin
        addr = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
      end else if (pick < 85) begin
        addr = sb.page_base[$urandom_range(0, sb.page_count - 1)] | 48'($urandom_range(0, 4095));
      end else begin
        addr = random_addr();
      end
      send_request(OpFree, random_addr(), addr);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_phase(logic [12:0] size, int unsigned count);
    wait_idle();
    write_obj_size(size);
    for (int unsigned n = 0; n < count; n++) begin
      send_random();
    end
  endtask

  // Result side: random stalls, with one long hold-off on request.
  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = hold_request ? 400 : (quiet ? 0 : $urandom_range(0, 15));
      hold_request = 0;
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_result(out_if.status, out_if.obj_addr, out_if.opened_page);
    end
  end

  initial begin
    logic [47:0] first_obj;
    quiet = 0;
    hold_request = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.op = OpAlloc;
    in_if.fresh_page = '0;
    in_if.free_addr = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset object size.
    send_request(OpFree, '0, '1);              // no page open yet
    send_request(OpAlloc, '1, '0);             // unaligned fresh page
    first_obj = sb.live_q[0];
    send_request(OpAlloc, 48'h0, '0);
    send_request(OpFree, '0, first_obj);
    send_request(OpFree, '0, first_obj);       // already free
    send_request(OpAlloc, 48'h5555_5555_5000, '0);
    send_request(OpFree, '1, 48'h0000_0000_0FFF);
    wait_idle();
    write_obj_size(13'd8191);                  // larger than a page
    send_request(OpAlloc, 48'hAAAA_AAAA_A000, '0);
    send_request(OpFree, '0, sb.page_base[0]);
    wait_idle();
    write_obj_size(13'd96);                    // offset can land past the last slot
    send_request(OpFree, '0, sb.page_base[0] | 48'hFFF);
    send_request(OpAlloc, random_addr(), '0);
    wait_idle();
    write_obj_size(13'd0);
    send_request(OpAlloc, random_addr(), '0);
    send_request(OpFree, '0, sb.page_base[0] | 48'h7F);
    wait_idle();
    write_obj_size(13'd4096);                  // one slot per page: run out of pages
    for (int unsigned n = 0; n < 18; n++) begin
      send_request(OpAlloc, random_addr(), '0);
    end

    random_phase(13'd4096, 100);
    random_phase(13'd32, 100);
    // Back-pressure: results held off while requests keep coming.
    quiet = 1;
    hold_request = 1;
    for (int unsigned n = 0; n < 30; n++) begin
      send_random();
    end
    quiet = 0;
    random_phase(13'd1024, 100);
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    for (int unsigned n = 0; n < 50; n++) begin
      send_random();
    end
    random_phase(13'd96, 100);
    random_phase(13'd0, 100);
    random_phase(13'd64, 60);
    random_phase(13'd2000, 80);
    wait_idle();

    $display("Covered %0d requests and %0d results: %0d pages opened, %0d out of pages,",
             sb.requests, sb.results, sb.opened, sb.no_pages);
    $display("%0d frees off any page, object sizes from 0 to 8191.", sb.not_found);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_if.sv
hw/rtl/bsa_ctrl.sv
hw/rtl/bsa_datapath.sv
hw/rtl/bitmap_slot_allocator.sv
sim/tb.sv
